@@ hw/rtl/mbd_pkg.sv @@
// motion burst detector package: payload structs, register codes, reset values
// used by every module of the block but mbd_ram, no dependencies
package mbd_pkg;

    localparam int MAG_W          = 16;
    localparam int RATE_W         = 23;
    localparam int TIME_W         = 32;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int WINDOW_DEFAULT = 32;

    localparam logic [CFG_W-1:0] CLAMP_LIMIT_RESET    = 16'd10000;
    localparam logic [CFG_W-1:0] MEAN_THRESHOLD_RESET = 16'd9500;
    localparam logic [CFG_W-1:0] HOLD_TIME_MS_RESET   = 16'd600;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLAMP_LIMIT    = 2'd0,
        CFG_MEAN_THRESHOLD = 2'd1,
        CFG_HOLD_TIME_MS   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [RATE_W-1:0] rate_mdps;
        logic [TIME_W-1:0]        now_ms;
    } t_in;

    typedef struct packed {
        logic             alert;
        logic [MAG_W-1:0] window_mean;
    } t_out;

endpackage

@@ hw/rtl/mbd_ram.sv @@
// generic single write port ram with one registered read port
// no dependencies
module mbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/mbd_front.sv @@
// input stage: takes a sample transfer, forms the clamped magnitude
// depends on mbd_pkg
module mbd_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  mbd_pkg::t_in                 i_in,
    input  logic [mbd_pkg::CFG_W-1:0]    i_clamp_limit,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [mbd_pkg::MAG_W-1:0]    o_mag,
    output logic [mbd_pkg::TIME_W-1:0]   o_now
);

    logic                          r_valid;
    logic [mbd_pkg::MAG_W-1:0]     r_mag;
    logic [mbd_pkg::TIME_W-1:0]    r_now;
    logic [mbd_pkg::RATE_W-1:0]    rate_u;
    logic [mbd_pkg::RATE_W-1:0]    abs_val;
    logic [mbd_pkg::MAG_W-1:0]     n_mag;
    logic                          accept;

    assign o_in_ready = !r_valid || i_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign rate_u     = i_in.rate_mdps;

    always_comb begin
        abs_val = rate_u[mbd_pkg::RATE_W-1] ? (mbd_pkg::RATE_W'(0) - rate_u) : rate_u;
        if (abs_val > mbd_pkg::RATE_W'(i_clamp_limit)) begin
            n_mag = i_clamp_limit;
        end else begin
            n_mag = abs_val[mbd_pkg::MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
        if (accept) begin
            r_mag <= n_mag;
            r_now <= i_in.now_ms;
        end
    end

    assign o_valid = r_valid;
    assign o_mag   = r_mag;
    assign o_now   = r_now;

endmodule

@@ hw/rtl/mbd_core.sv @@
// window stage: history ring, running sum, arm time and alert decision
// depends on mbd_pkg and mbd_ram
module mbd_core #(
    parameter int WINDOW = mbd_pkg::WINDOW_DEFAULT
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  logic [mbd_pkg::MAG_W-1:0]                 i_mag,
    input  logic [mbd_pkg::TIME_W-1:0]                i_now,
    input  logic [mbd_pkg::MAG_W+$clog2(WINDOW)-1:0]  i_thr_scaled,
    input  logic [mbd_pkg::CFG_W-1:0]                 i_hold_time,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output logic                                      o_alert,
    output logic [mbd_pkg::MAG_W+$clog2(WINDOW)-1:0]  o_sum
);

    localparam int LW = $clog2(WINDOW);
    localparam int SW = mbd_pkg::MAG_W + LW;

    logic                           r_valid;
    logic                           r_alert;
    logic [SW-1:0]                  r_sum;
    logic [LW-1:0]                  r_slot;
    logic [WINDOW-1:0]              r_filled;
    logic                           r_old_valid;
    logic [mbd_pkg::TIME_W-1:0]     r_armed_since;

    logic                           xfer;
    logic [LW-1:0]                  slot_next;
    logic [mbd_pkg::MAG_W-1:0]      ram_rdata;
    logic [mbd_pkg::MAG_W-1:0]      old_mag;
    logic [SW-1:0]                  n_sum;
    logic [mbd_pkg::TIME_W-1:0]     elapsed;
    logic                           above;
    logic                           n_alert;
    logic [mbd_pkg::TIME_W-1:0]     n_armed_since;

    assign o_ready   = !r_valid || i_ready;
    assign xfer      = i_valid && o_ready;
    assign slot_next = (r_slot == LW'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
    assign old_mag   = r_old_valid ? ram_rdata : '0;

    // the ring entry for the next slot is fetched one transfer ahead
    mbd_ram #(
        .WIDTH(mbd_pkg::MAG_W),
        .DEPTH(WINDOW)
    ) u_hist (
        .i_clk  (i_clk),
        .i_we   (xfer),
        .i_waddr(r_slot),
        .i_wdata(i_mag),
        .i_re   (xfer),
        .i_raddr(slot_next),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_sum   = r_sum - SW'(old_mag) + SW'(i_mag);
        above   = n_sum > i_thr_scaled;
        elapsed = i_now - r_armed_since;
        n_alert = 1'b0;
        n_armed_since = r_armed_since;
        if (above) begin
            if (r_armed_since != '0) begin
                n_alert = elapsed > mbd_pkg::TIME_W'(i_hold_time);
            end else begin
                n_armed_since = i_now;
            end
        end else begin
            n_armed_since = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= 1'b0;
            r_sum         <= '0;
            r_slot        <= '0;
            r_filled      <= '0;
            r_old_valid   <= 1'b0;
            r_armed_since <= '0;
            r_alert       <= 1'b0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (xfer) begin
                r_sum            <= n_sum;
                r_slot           <= slot_next;
                r_filled[r_slot] <= 1'b1;
                r_old_valid      <= r_filled[slot_next];
                r_armed_since    <= n_armed_since;
                r_alert          <= n_alert;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_alert = r_alert;
    assign o_sum   = r_sum;

endmodule

@@ hw/rtl/mbd_mean.sv @@
// output stage: window mean by reciprocal multiply, result register
// depends on mbd_pkg
module mbd_mean #(
    parameter int WINDOW = mbd_pkg::WINDOW_DEFAULT
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  logic                                      i_alert,
    input  logic [mbd_pkg::MAG_W+$clog2(WINDOW)-1:0]  i_sum,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output mbd_pkg::t_out                             o_out
);

    localparam int LW = $clog2(WINDOW);
    localparam int SW = mbd_pkg::MAG_W + LW;
    localparam int K  = SW + LW;
    localparam int RW = SW + 1;
    localparam int PW = SW + RW;
    localparam logic [63:0] RECIP64 =
        ((64'd1 << K) + 64'(WINDOW - 1)) / 64'(WINDOW);
    localparam logic [RW-1:0] RECIP = RECIP64[RW-1:0];

    logic          r_valid;
    mbd_pkg::t_out r_out;
    logic [PW-1:0] prod;

    assign o_ready = !r_valid || i_ready;
    assign prod    = PW'(i_sum) * PW'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_out.alert       <= i_alert;
            r_out.window_mean <= prod[K +: mbd_pkg::MAG_W];
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

@@ hw/rtl/motion_burst_detector_unit.sv @@
// motion burst detector top level: configuration registers and the three stages
// depends on mbd_pkg, mbd_front, mbd_core, mbd_mean
//
// Takes one gyro rate sample per transfer and returns one result per sample:
// the window mean of the clamped magnitudes and an alert flag. The block takes
// one sample every clock cycle while the output side is ready; each result is
// registered in the front, window and mean stages in turn. The rate is set by
// the running sum and arm time update in the window stage, which handles one
// sample per cycle unless stalled, with the history ring entry read from the ram
// one sample ahead. The ring needs no clearing pass after reset: per-entry valid
// bits make unwritten entries read as zero. Configuration writes are taken in
// any cycle and should be made while no sample is in flight.
module motion_burst_detector_unit #(
    parameter int WINDOW = mbd_pkg::WINDOW_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  mbd_pkg::t_in                      i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output mbd_pkg::t_out                     o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mbd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mbd_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int LW = $clog2(WINDOW);
    localparam int SW = mbd_pkg::MAG_W + LW;

    logic [mbd_pkg::CFG_W-1:0]   r_clamp_limit;
    logic [mbd_pkg::CFG_W-1:0]   r_mean_threshold;
    logic [mbd_pkg::CFG_W-1:0]   r_hold_time_ms;
    logic [SW-1:0]               r_thr_scaled;

    logic                        front_valid;
    logic                        core_ready;
    logic [mbd_pkg::MAG_W-1:0]   front_mag;
    logic [mbd_pkg::TIME_W-1:0]  front_now;
    logic                        core_valid;
    logic                        mean_ready;
    logic                        core_alert;
    logic [SW-1:0]               core_sum;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp_limit    <= mbd_pkg::CLAMP_LIMIT_RESET;
            r_mean_threshold <= mbd_pkg::MEAN_THRESHOLD_RESET;
            r_hold_time_ms   <= mbd_pkg::HOLD_TIME_MS_RESET;
            r_thr_scaled     <= SW'(mbd_pkg::MEAN_THRESHOLD_RESET * SW'(WINDOW));
        end else begin
            r_thr_scaled <= SW'(r_mean_threshold * SW'(WINDOW));
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    mbd_pkg::CFG_CLAMP_LIMIT:    r_clamp_limit    <= i_cfg_data;
                    mbd_pkg::CFG_MEAN_THRESHOLD: r_mean_threshold <= i_cfg_data;
                    mbd_pkg::CFG_HOLD_TIME_MS:   r_hold_time_ms   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    mbd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_clamp_limit(r_clamp_limit),
        .o_valid      (front_valid),
        .i_ready      (core_ready),
        .o_mag        (front_mag),
        .o_now        (front_now)
    );

    mbd_core #(
        .WINDOW(WINDOW)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (front_valid),
        .o_ready     (core_ready),
        .i_mag       (front_mag),
        .i_now       (front_now),
        .i_thr_scaled(r_thr_scaled),
        .i_hold_time (r_hold_time_ms),
        .o_valid     (core_valid),
        .i_ready     (mean_ready),
        .o_alert     (core_alert),
        .o_sum       (core_sum)
    );

    mbd_mean #(
        .WINDOW(WINDOW)
    ) u_mean (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(core_valid),
        .o_ready(mean_ready),
        .i_alert(core_alert),
        .i_sum  (core_sum),
        .o_valid(o_out_valid),
        .i_ready(i_out_ready),
        .o_out  (o_out)
    );

endmodule

@@ sim/testbench.sv @@
// testbench for motion_burst_detector_unit: directed and random rate samples, with the
// window mean and alert checked against an in-bench predictor
// depends on mbd_pkg and the rtl of motion_burst_detector_unit
module testbench;
    import mbd_pkg::*;

    localparam int WINDOW = WINDOW_DEFAULT;
    localparam int SLOT_W = $clog2(WINDOW);

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in                  i_in        = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out                 o_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    motion_burst_detector_unit #(.WINDOW(WINDOW)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state
    logic [MAG_W-1:0]  ring_mag [WINDOW] = '{default: '0};
    logic [SLOT_W-1:0] ring_slot = '0;
    logic [20:0]       mag_sum   = '0;
    logic [31:0]       armed_at  = '0;
    logic [CFG_W-1:0]  clamp_lim = CLAMP_LIMIT_RESET;
    logic [CFG_W-1:0]  mean_thr  = MEAN_THRESHOLD_RESET;
    logic [CFG_W-1:0]  hold_ms   = HOLD_TIME_MS_RESET;

    t_in  rate_q[$];
    t_out mean_alert_q[$];

    int unsigned mismatch_count = 0;
    bit          in_taken = 1'b0;
    bit          idle_on  = 1'b1;
    bit          hold_rx  = 1'b0;
    int unsigned tx_wait  = 0;
    int unsigned rx_wait  = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic t_out burst_predict(input t_in s);
        logic [23:0]      mag_wide;
        logic [MAG_W-1:0] mag;
        logic [31:0]      elapsed;
        t_out             r;
        mag_wide = s.rate_mdps[RATE_W-1] ? 24'd0 - {s.rate_mdps[RATE_W-1], s.rate_mdps}
                                         : {1'b0, s.rate_mdps};
        mag = (mag_wide > {8'd0, clamp_lim}) ? clamp_lim : mag_wide[MAG_W-1:0];
        mag_sum = mag_sum - 21'(ring_mag[ring_slot]) + 21'(mag);
        ring_mag[ring_slot] = mag;
        ring_slot = (ring_slot == SLOT_W'(WINDOW - 1)) ? '0 : ring_slot + 1'b1;
        r.window_mean = MAG_W'(mag_sum / WINDOW);
        r.alert = 1'b0;
        // exact mean test, not the floored one
        if (32'(mag_sum) > 32'(mean_thr) * WINDOW) begin
            if (armed_at != 0) begin
                elapsed = s.now_ms - armed_at;
                r.alert = elapsed > 32'(hold_ms);
            end else begin
                armed_at = s.now_ms;
            end
        end else begin
            armed_at = '0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 100) $display("mismatch at %0t: %s", $time, msg);
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // monitor: config and input transfers feed the predictor, output transfers are checked
    always @(posedge i_clk) begin : monitor
        t_out want;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CLAMP_LIMIT:    clamp_lim = i_cfg_data;
                    CFG_MEAN_THRESHOLD: mean_thr  = i_cfg_data;
                    CFG_HOLD_TIME_MS:   hold_ms   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                mean_alert_q.push_back(burst_predict(i_in));
                in_taken = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                if (mean_alert_q.size() == 0) begin
                    report_mismatch($sformatf("result alert=%0b mean=%0d with nothing expected",
                                              o_out.alert, o_out.window_mean));
                end else begin
                    want = mean_alert_q.pop_front();
                    if (o_out.alert !== want.alert)
                        report_mismatch($sformatf("alert got %0b want %0b",
                                                  o_out.alert, want.alert));
                    if (o_out.window_mean !== want.window_mean)
                        report_mismatch($sformatf("window_mean got %0d want %0d",
                                                  o_out.window_mean, want.window_mean));
                end
            end
        end
    end

    // sender
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (tx_wait > 0) begin
                i_in_valid <= 1'b0;
                tx_wait--;
            end else if (rate_q.size() != 0) begin
                i_in       <= rate_q.pop_front();
                i_in_valid <= 1'b1;
                tx_wait = pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (hold_rx) begin
            i_out_ready <= 1'b0;
        end else if (rx_wait > 0) begin
            i_out_ready <= 1'b0;
            rx_wait--;
        end else begin
            i_out_ready <= 1'b1;
            rx_wait = pick_gap();
        end
    end

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input logic [CFG_W-1:0] clamp_v, input logic [CFG_W-1:0] thr_v,
                            input logic [CFG_W-1:0] hold_v);
        cfg_write(CFG_CLAMP_LIMIT, clamp_v);
        cfg_write(CFG_MEAN_THRESHOLD, thr_v);
        cfg_write(CFG_HOLD_TIME_MS, hold_v);
        @(posedge i_clk);
    endtask

    task automatic add_rate(input int rate, input logic [31:0] now);
        t_in s;
        s.rate_mdps = rate[RATE_W-1:0];
        s.now_ms    = now;
        rate_q.push_back(s);
    endtask

    // bursts around the threshold with mostly advancing timestamps, plus quiet stretches and noise
    task automatic add_random_run(input int unsigned count, input int level,
                                  input int unsigned tick_max, input logic [31:0] start_ms);
        logic [31:0] now;
        int unsigned left, seg, kind, r;
        int          bias, mag;
        now  = start_ms;
        left = count;
        while (left > 0) begin
            kind = $urandom_range(0, 99);
            seg  = $urandom_range(8, 60);
            if (seg > left) seg = left;
            bias = int'($urandom_range(0, level / 8 + level / 4)) - level / 8;
            repeat (seg) begin
                r = $urandom_range(0, 99);
                if (r < 2) now = now - $urandom_range(1, 5000);
                else if (r == 2) now = '0;
                else now = now + $urandom_range(0, tick_max);
                if (kind < 85) begin
                    if (kind < 70)
                        mag = level + bias + int'($urandom_range(0, level / 8)) - level / 16;
                    else
                        mag = int'($urandom_range(0, level / 2));
                    if (mag < 0) mag = 0;
                    add_rate($urandom_range(0, 1) ? -mag : mag, now);
                end else begin
                    add_rate(int'($urandom()), now);
                end
            end
            left -= seg;
        end
    endtask

    task automatic wait_idle();
        @(posedge i_clk);
        while (rate_q.size() != 0 || i_in_valid || mean_alert_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0] clamp_v, thr_v, hold_v;
        int               level;
        logic [31:0]      start_ms;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sum equal to threshold times window, then mean floor equal but exact mean above
        set_regs(16'hFFFF, 16'd1, 16'd10);
        add_rate(32, 1);
        add_rate(1, 2);
        add_rate(-1, 12);
        add_rate(0, 13);
        add_rate(5, 1);
        wait_idle();

        // unreachable threshold disarms, clamping at the reset limit
        set_regs(16'd10000, 16'hFFFF, 16'hFFFF);
        add_rate(10001, 100);
        add_rate(-10000, 200);
        wait_idle();

        // arm at time zero, most negative input, hold across timestamp wrap
        set_regs(16'hFFFF, 16'd0, 16'd5);
        add_rate(-4194304, 32'd0);
        add_rate(4194303, 32'hFFFF_FFFE);
        add_rate(65536, 32'd3);
        add_rate(-65536, 32'd4);
        add_rate(0, 32'hFFFF_FFFF);
        wait_idle();

        // zero clamp only affects new entries
        set_regs(16'd0, 16'hFFFF, 16'd0);
        add_rate(4194303, 7);
        add_rate(-4194304, 8);
        add_rate(123456, 9);
        wait_idle();

        for (int p = 0; p < 14; p++) begin
            case (p)
                0: begin
                    clamp_v = 16'hFFFF; thr_v = 16'hFFFF; hold_v = 16'hFFFF;
                end
                1: begin
                    clamp_v = 16'd0; thr_v = 16'd0; hold_v = 16'd0;
                end
                2: begin
                    clamp_v = 16'hFFFF; thr_v = 16'd0; hold_v = 16'd0;
                end
                3: begin
                    clamp_v = CLAMP_LIMIT_RESET;
                    thr_v   = MEAN_THRESHOLD_RESET;
                    hold_v  = HOLD_TIME_MS_RESET;
                end
                default: begin
                    clamp_v = CFG_W'($urandom_range(500, 65535));
                    thr_v   = CFG_W'($urandom_range(0, clamp_v));
                    hold_v  = CFG_W'($urandom_range(0, 2000));
                end
            endcase
            level    = (thr_v == 0) ? int'($urandom_range(20, 4000)) : int'(thr_v);
            start_ms = (p % 4 == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 4000) : $urandom();
            idle_on  = !(p == 4 || p == 9);
            set_regs(clamp_v, thr_v, hold_v);
            // long output stall so the block backs up into its input
            if (p == 5) hold_rx = 1'b1;
            add_random_run(125, level, hold_v / 10 + 3, start_ms);
            if (p == 5) begin
                repeat (300) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            wait_idle();
        end

        if (mismatch_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

@@ motion_burst_detector_unit.f @@
hw/rtl/mbd_pkg.sv
hw/rtl/mbd_ram.sv
hw/rtl/mbd_front.sv
hw/rtl/mbd_core.sv
hw/rtl/mbd_mean.sv
hw/rtl/motion_burst_detector_unit.sv
sim/testbench.sv
